### hw/rtl/aimmenc_pkg.sv
// Shared types and opcode constants for the ARM immediate instruction encoder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package aimmenc_pkg;

    localparam int REG_W  = 4;
    localparam int MODE_W = 5;
    localparam int WORD_W = 32;
    localparam int STACK_DEPTH = 3;

    // Opcode times two, S bit clear
    localparam logic [MODE_W-1:0] OPC_AND = 5'h00;
    localparam logic [MODE_W-1:0] OPC_EOR = 5'h02;
    localparam logic [MODE_W-1:0] OPC_SUB = 5'h04;
    localparam logic [MODE_W-1:0] OPC_ADD = 5'h08;
    localparam logic [MODE_W-1:0] OPC_ORR = 5'h18;
    localparam logic [MODE_W-1:0] OPC_MOV = 5'h1a;
    localparam logic [MODE_W-1:0] OPC_BIC = 5'h1c;
    localparam logic [MODE_W-1:0] OPC_MVN = 5'h1e;

    localparam logic [WORD_W-1:0] COND_ALWAYS = 32'he000_0000;
    localparam logic [WORD_W-1:0] IMM_FLAG    = 32'h0200_0000;

    localparam logic [REG_W-1:0] SCRATCH_RESET = 4'd6;

    typedef struct packed {
        logic              valid;
        logic              last;
        logic [WORD_W-1:0] word;
    } emit_t;

    typedef struct packed {
        logic [WORD_W-1:0] cnt_operand;
        logic [WORD_W-1:0] rot_operand;
        logic [WORD_W-1:0] win_operand;
    } unit_req_t;

    typedef struct packed {
        logic [5:0]        ones;
        logic [WORD_W-1:0] rot_next;
        logic              fits;
        logic [WORD_W-1:0] chunk;
        logic [WORD_W-1:0] rest;
    } unit_rsp_t;

endpackage

`default_nettype wire

### hw/rtl/aimmenc_shared_unit.sv
// Shared arithmetic unit: population count, rotate-left-by-two with 8-bit fit test,
// and lowest even-aligned byte window split. Depends on aimmenc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module aimmenc_shared_unit (
    input  aimmenc_pkg::unit_req_t req,
    output aimmenc_pkg::unit_rsp_t rsp
);
    import aimmenc_pkg::*;

    logic [1:0] sum1 [16];
    logic [2:0] sum2 [8];
    logic [3:0] sum3 [4];
    logic [4:0] sum4 [2];

    logic [WORD_W-1:0] low_bit;
    logic [15:0]       pair_hot;
    logic [3:0]        pair_idx;
    logic [WORD_W-1:0] mask;

    // Population count as a balanced adder tree
    always_comb
    begin
        for (int k = 0; k < 16; k++)
        begin
            sum1[k] = {1'b0, req.cnt_operand[2*k]} + {1'b0, req.cnt_operand[2*k+1]};
        end
        for (int k = 0; k < 8; k++)
        begin
            sum2[k] = {1'b0, sum1[2*k]} + {1'b0, sum1[2*k+1]};
        end
        for (int k = 0; k < 4; k++)
        begin
            sum3[k] = {1'b0, sum2[2*k]} + {1'b0, sum2[2*k+1]};
        end
        for (int k = 0; k < 2; k++)
        begin
            sum4[k] = {1'b0, sum3[2*k]} + {1'b0, sum3[2*k+1]};
        end
    end

    assign rsp.ones     = {1'b0, sum4[0]} + {1'b0, sum4[1]};
    assign rsp.rot_next = {req.rot_operand[29:0], req.rot_operand[31:30]};
    assign rsp.fits     = (req.rot_operand[31:8] == 24'd0);

    // Window starts at the even position holding the lowest set bit
    assign low_bit = req.win_operand & (~req.win_operand + 32'd1);

    always_comb
    begin
        pair_idx = 4'd0;
        for (int k = 0; k < 16; k++)
        begin
            pair_hot[k] = low_bit[2*k] | low_bit[2*k+1];
            pair_idx    = pair_idx | (pair_hot[k] ? 4'(k) : 4'd0);
        end
        if (req.win_operand == 32'd0)
        begin
            pair_idx = 4'd15;
        end
    end

    assign mask      = 32'h0000_00ff << {pair_idx, 1'b0};
    assign rsp.chunk = req.win_operand & mask;
    assign rsp.rest  = req.win_operand & ~mask;

endmodule

`default_nettype wire

### hw/rtl/aimmenc_seq.sv
// Encoding sequencer: cheaper-form choice, rotation search, chunk stack and word emission.
// Depends on aimmenc_pkg; drives the shared unit in aimmenc_shared_unit.
`timescale 1ns / 1ps
`default_nettype none

module aimmenc_seq (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            in_valid,
    output logic                           in_ready,
    input  wire  [aimmenc_pkg::MODE_W-1:0] in_mode,
    input  wire  [aimmenc_pkg::REG_W-1:0]  in_dest,
    input  wire  [aimmenc_pkg::REG_W-1:0]  in_src,
    input  wire  [aimmenc_pkg::WORD_W-1:0] in_imm,
    input  wire  [aimmenc_pkg::REG_W-1:0]  scratch,
    input  wire                            out_free,
    output aimmenc_pkg::emit_t             emit,
    output aimmenc_pkg::unit_req_t         unit_req,
    input  aimmenc_pkg::unit_rsp_t         unit_rsp
);
    import aimmenc_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CNT   = 3'd1;
    localparam logic [2:0] ST_FORM  = 3'd2;
    localparam logic [2:0] ST_SRCH  = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;
    localparam logic [2:0] ST_FINAL = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic [MODE_W-1:0] cur_op_reg, cur_op_next;
    logic [REG_W-1:0]  cur_rd_reg, cur_rd_next;
    logic [REG_W-1:0]  cur_rn_reg, cur_rn_next;
    logic [WORD_W-1:0] val_reg, val_next;
    logic [WORD_W-1:0] v_reg, v_next;
    logic [3:0]        ror_reg, ror_next;
    logic [5:0]        ones_reg, ones_next;
    logic              top_reg, top_next;
    logic              fin_reg, fin_next;
    logic [MODE_W-1:0] fin_op_reg, fin_op_next;
    logic [REG_W-1:0]  fin_rd_reg, fin_rd_next;
    logic [REG_W-1:0]  fin_rn_reg, fin_rn_next;
    logic [MODE_W-1:0] chunk_op_reg, chunk_op_next;
    logic [1:0]        sp_reg, sp_next;
    logic [WORD_W-1:0] stack_reg [STACK_DEPTH];
    logic              push;

    logic              noop;
    logic              plain;
    logic [MODE_W-1:0] form_op;
    logic [WORD_W-1:0] form_val;
    logic [WORD_W-1:0] neg_val;
    logic [WORD_W-1:0] stack_top;

    assign neg_val   = ~val_reg + 32'd1;
    assign stack_top = stack_reg[sp_reg - 2'd1];

    assign unit_req.cnt_operand = (state_reg == ST_FORM) ? neg_val : val_reg;
    assign unit_req.rot_operand = v_reg;
    assign unit_req.win_operand = val_reg;

    assign plain = (cur_op_reg == OPC_MOV) || (cur_op_reg == OPC_MVN);

    // A request that leaves its register unchanged produces nothing
    always_comb
    begin
        noop = 1'b0;
        if (top_reg && (cur_rd_reg == cur_rn_reg))
        begin
            if ((cur_op_reg == OPC_ADD || cur_op_reg == OPC_SUB || cur_op_reg == OPC_ORR ||
                 cur_op_reg == OPC_EOR || cur_op_reg == OPC_BIC) && val_reg == 32'd0)
            begin
                noop = 1'b1;
            end
            if (cur_op_reg == OPC_AND && val_reg == 32'hffff_ffff)
            begin
                noop = 1'b1;
            end
        end
    end

    always_comb
    begin
        form_op  = cur_op_reg;
        form_val = val_reg;
        unique case ({cur_op_reg[MODE_W-1:1], 1'b0})
            OPC_ADD:
            begin
                if (ones_reg > unit_rsp.ones)
                begin
                    form_val = neg_val;
                    form_op  = OPC_SUB | {4'd0, cur_op_reg[0]};
                end
            end
            OPC_AND:
            begin
                // ~val has 32 minus the set bits of val
                if (ones_reg > 6'd16)
                begin
                    form_val = ~val_reg;
                    form_op  = OPC_BIC | {4'd0, cur_op_reg[0]};
                end
            end
            OPC_MOV:
            begin
                if (val_reg[31:8] == 24'hff_ffff)
                begin
                    form_val = ~val_reg;
                    form_op  = OPC_MVN | {4'd0, cur_op_reg[0]};
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        cur_op_next   = cur_op_reg;
        cur_rd_next   = cur_rd_reg;
        cur_rn_next   = cur_rn_reg;
        val_next      = val_reg;
        v_next        = v_reg;
        ror_next      = ror_reg;
        ones_next     = ones_reg;
        top_next      = top_reg;
        fin_next      = fin_reg;
        fin_op_next   = fin_op_reg;
        fin_rd_next   = fin_rd_reg;
        fin_rn_next   = fin_rn_reg;
        chunk_op_next = chunk_op_reg;
        sp_next       = sp_reg;
        push          = 1'b0;
        in_ready      = 1'b0;
        emit.valid    = 1'b0;
        emit.last     = 1'b0;
        emit.word     = COND_ALWAYS | IMM_FLAG |
                        {7'd0, cur_op_reg, cur_rn_reg, cur_rd_reg, ror_reg, v_reg[7:0]};

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cur_op_next = in_mode;
                    cur_rd_next = in_dest;
                    cur_rn_next = in_src;
                    val_next    = in_imm;
                    top_next    = 1'b1;
                    fin_next    = 1'b0;
                    sp_next     = 2'd0;
                    state_next  = ST_CNT;
                end
            end
            ST_CNT:
            begin
                ones_next  = unit_rsp.ones;
                state_next = ST_FORM;
            end
            ST_FORM:
            begin
                if (noop)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    cur_op_next = form_op;
                    val_next    = form_val;
                    v_next      = form_val;
                    ror_next    = 4'd0;
                    state_next  = ST_SRCH;
                end
            end
            ST_SRCH:
            begin
                if (unit_rsp.fits)
                begin
                    state_next = ST_EMIT;
                end
                else if (ror_reg == 4'd15)
                begin
                    // Split: park the low window, build the rest with MOV or MVN
                    if (top_reg)
                    begin
                        fin_next    = !plain;
                        fin_op_next = cur_op_reg;
                        fin_rd_next = cur_rd_reg;
                        fin_rn_next = cur_rn_reg;
                    end
                    chunk_op_next = (cur_op_reg == OPC_MVN) ? OPC_BIC : OPC_ORR;
                    cur_op_next   = (cur_op_reg == OPC_MVN) ? OPC_MVN : OPC_MOV;
                    cur_rd_next   = plain ? cur_rd_reg : scratch;
                    cur_rn_next   = '0;
                    val_next      = unit_rsp.rest;
                    push          = 1'b1;
                    sp_next       = sp_reg + 2'd1;
                    top_next      = 1'b0;
                    state_next    = ST_CNT;
                end
                else
                begin
                    v_next   = unit_rsp.rot_next;
                    ror_next = ror_reg + 4'd1;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    emit.valid = 1'b1;
                    emit.last  = (sp_reg == 2'd0) && !fin_reg;
                    if (sp_reg != 2'd0)
                    begin
                        // Pop the highest pending window into the scratch build
                        val_next    = stack_top;
                        v_next      = stack_top;
                        ror_next    = 4'd0;
                        sp_next     = sp_reg - 2'd1;
                        cur_op_next = chunk_op_reg;
                        cur_rn_next = cur_rd_reg;
                        state_next  = ST_SRCH;
                    end
                    else if (fin_reg)
                    begin
                        state_next = ST_FINAL;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_FINAL:
            begin
                emit.word = COND_ALWAYS |
                            {7'd0, fin_op_reg, fin_rn_reg, fin_rd_reg, 8'd0, scratch};
                if (out_free)
                begin
                    emit.valid = 1'b1;
                    emit.last  = 1'b1;
                    fin_next   = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            top_reg   <= 1'b0;
            fin_reg   <= 1'b0;
            sp_reg    <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            top_reg   <= top_next;
            fin_reg   <= fin_next;
            sp_reg    <= sp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_op_reg   <= cur_op_next;
        cur_rd_reg   <= cur_rd_next;
        cur_rn_reg   <= cur_rn_next;
        val_reg      <= val_next;
        v_reg        <= v_next;
        ror_reg      <= ror_next;
        ones_reg     <= ones_next;
        fin_op_reg   <= fin_op_next;
        fin_rd_reg   <= fin_rd_next;
        fin_rn_reg   <= fin_rn_next;
        chunk_op_reg <= chunk_op_next;
        if (push)
        begin
            stack_reg[sp_reg] <= unit_rsp.chunk;
        end
    end

`ifndef NO_ASSERTIONS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("sequencer still ready after taking a transaction");

    a_emit_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
        emit.valid |-> out_free)
        else $error("word emitted while output register is occupied");

    a_final_not_plain: assert property (@(posedge clk) disable iff (!rst_n)
        fin_reg |-> (fin_op_reg != OPC_MOV && fin_op_reg != OPC_MVN))
        else $error("register-form word pending for a plain MOV or MVN");

    a_last_ends_request: assert property (@(posedge clk) disable iff (!rst_n)
        (emit.valid && emit.last) |=> (state_reg == ST_IDLE))
        else $error("last word emitted but sequence continues");
`endif

endmodule

`default_nettype wire

### hw/rtl/aimmenc_out_reg.sv
// Output register stage for encoded instruction words on the master stream side.
// Depends on aimmenc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module aimmenc_out_reg (
    input  wire                            clk,
    input  wire                            rst_n,
    input  aimmenc_pkg::emit_t             emit,
    output logic                           out_free,
    output logic                           m_tvalid,
    input  wire                            m_tready,
    output logic [aimmenc_pkg::WORD_W-1:0] m_tdata,
    output logic                           m_tlast
);
    import aimmenc_pkg::*;

    logic              valid_reg;
    logic [WORD_W-1:0] data_reg;
    logic              last_reg;

    assign out_free = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (emit.valid)
        begin
            valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit.valid)
        begin
            data_reg <= emit.word;
            last_reg <= emit.last;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/arm_immediate_instruction_encoder_top.sv
// Top level of the ARM data-processing immediate encoder: scratch register,
// sequencer, shared unit and output stage. Depends on aimmenc_pkg and all aimmenc_* modules.
`timescale 1ns / 1ps
`default_nettype none

// Takes one data-processing request per slave transaction and returns zero to five
// condition-always instruction words, the final one flagged by m_tlast. The block takes
// a request only when idle and is busy until its last word is in the output register.
// Each encode level counts the set bits, chooses the form, then tries even rotations
// (1 to 16) in the shared rotate unit; each word is emitted when the output register is
// free. A split immediate re-runs the search for every chunk. A no-op request ends after
// the form choice with no words. Stalls on m_tready hold back word emission. cfg_wdata is
// taken as the scratch register number on any edge with cfg_we high (reset value 6);
// write it only when idle.
module arm_immediate_instruction_encoder_top (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [47:0] s_tdata,   // mode[4:0], dest_reg[8:5], src_reg[12:9], immediate[44:13]
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [31:0] m_tdata,   // instruction_word[31:0]
    output logic        m_tlast,
    input  wire         cfg_we,
    input  wire  [3:0]  cfg_wdata
);
    import aimmenc_pkg::*;

    logic [REG_W-1:0] scratch_reg;
    logic             out_free;
    emit_t            emit;
    unit_req_t        unit_req;
    unit_rsp_t        unit_rsp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scratch_reg <= SCRATCH_RESET;
        end
        else if (cfg_we)
        begin
            scratch_reg <= cfg_wdata;
        end
    end

    aimmenc_shared_unit u_unit (
        .req (unit_req),
        .rsp (unit_rsp)
    );

    aimmenc_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_mode  (s_tdata[4:0]),
        .in_dest  (s_tdata[8:5]),
        .in_src   (s_tdata[12:9]),
        .in_imm   (s_tdata[44:13]),
        .scratch  (scratch_reg),
        .out_free (out_free),
        .emit     (emit),
        .unit_req (unit_req),
        .unit_rsp (unit_rsp)
    );

    aimmenc_out_reg u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .emit     (emit),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

### verif/tb_top.sv
// Self-checking testbench for arm_immediate_instruction_encoder_top.
// Predicts the instruction words for each accepted request and compares every output word.
// Depends on aimmenc_pkg and the encoder RTL only.
`timescale 1ns / 1ps

module tb_top;

    import aimmenc_pkg::*;

    localparam logic [MODE_W-1:0] S_BIT   = 5'h01;
    localparam logic [MODE_W-1:0] OPC_TST = 5'h10;
    localparam int MAX_WORDS        = 5;
    localparam int SETTLE_CYCLES    = 200;
    localparam int LONG_HOLD_CYCLES = 400;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              last;
    } expected_word_t;

    // One pending piece of encoding work: either a finished word or a sub-encode
    typedef struct packed {
        logic              literal;
        logic [MODE_W-1:0] op;
        logic [REG_W-1:0]  rd;
        logic [REG_W-1:0]  rn;
        logic [WORD_W-1:0] val;
        logic [2:0]        depth;
    } encode_job_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;   // mode[4:0], dest_reg[8:5], src_reg[12:9], immediate[44:13]
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // instruction_word[31:0]
    logic        m_tlast;
    logic        cfg_we;
    logic [3:0]  cfg_wdata;

    expected_word_t   expected_words[$];
    logic [REG_W-1:0] scratch_model = SCRATCH_RESET;
    int               mismatch_count = 0;
    int               sink_stall = 0;
    bit               no_idle = 1'b0;
    int               long_hold_requests = 0;

    arm_immediate_instruction_encoder_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic encode_job_t make_job(input logic literal, input logic [MODE_W-1:0] op,
                                             input logic [REG_W-1:0] rd,
                                             input logic [REG_W-1:0] rn,
                                             input logic [WORD_W-1:0] val,
                                             input logic [2:0] depth);
        encode_job_t job;
        job.literal = literal;
        job.op      = op;
        job.rd      = rd;
        job.rn      = rn;
        job.val     = val;
        job.depth   = depth;
        return job;
    endfunction

    // Work out the instruction words for one request and queue them as expected
    function automatic void predict_words(input logic [MODE_W-1:0] mode,
                                          input logic [REG_W-1:0] rd,
                                          input logic [REG_W-1:0] rn,
                                          input logic [WORD_W-1:0] imm);
        encode_job_t       jobs[$];
        encode_job_t       job;
        logic [WORD_W-1:0] words[$];
        logic [MODE_W-1:0] op;
        logic              s;
        logic [WORD_W-1:0] val;
        logic [WORD_W-1:0] v;
        logic [WORD_W-1:0] mask;
        logic [3:0]        ror;
        logic [REG_W-1:0]  tmp;
        int                shift;
        bit                fits;
        bit                plain;
        expected_word_t    exp_word;

        jobs.push_back(make_job(1'b0, mode, rd, rn, imm, 3'd0));
        while (jobs.size() > 0)
        begin
            job = jobs.pop_back();
            if (job.literal)
            begin
                if (words.size() < MAX_WORDS)
                    words.push_back(job.val);
                continue;
            end
            if (job.depth > 4)
                continue;
            op  = job.op;
            val = job.val;
            // Drop requests that leave Rd unchanged
            if (job.rd == job.rn)
            begin
                if ((op == OPC_ADD || op == OPC_SUB || op == OPC_ORR || op == OPC_EOR ||
                     op == OPC_BIC) && val == 32'd0)
                    continue;
                if (op == OPC_AND && val == 32'hffff_ffff)
                    continue;
            end
            s = op[0];
            case ({op[4:1], 1'b0})
                OPC_ADD:
                    if ($countones(val) > $countones(32'd0 - val))
                    begin
                        val = 32'd0 - val;
                        op  = {OPC_SUB[4:1], s};
                    end
                OPC_AND:
                    if ($countones(val) > $countones(~val))
                    begin
                        val = ~val;
                        op  = {OPC_BIC[4:1], s};
                    end
                OPC_MOV:
                    if ((~val & ~32'hff) == 32'd0)
                    begin
                        val = ~val;
                        op  = {OPC_MVN[4:1], s};
                    end
                default:
                    ;
            endcase

            v    = val;
            ror  = 4'd0;
            fits = (v[31:8] == 24'd0);
            while (!fits && ror < 4'd15)
            begin
                ror  = ror + 4'd1;
                v    = {v[29:0], v[31:30]};
                fits = (v[31:8] == 24'd0);
            end

            if (fits)
            begin
                if (words.size() < MAX_WORDS)
                    words.push_back(COND_ALWAYS | IMM_FLAG |
                                    {7'd0, op, job.rn, job.rd, ror, v[7:0]});
            end
            else
            begin
                plain = (op == OPC_MOV) || (op == OPC_MVN);
                tmp   = plain ? job.rd : scratch_model;
                shift = 0;
                while (shift < 30 && (val & (32'd3 << shift)) == 32'd0)
                    shift += 2;
                mask = 32'hff << shift;
                // Push in reverse: build the rest, add the low chunk, then the final operation
                if (!plain)
                    jobs.push_back(make_job(1'b1, op, job.rd, job.rn,
                                            COND_ALWAYS | {7'd0, op, job.rn, job.rd, 8'd0,
                                                           scratch_model}, 3'd0));
                if (op == OPC_MVN)
                begin
                    jobs.push_back(make_job(1'b0, OPC_BIC, tmp, tmp, val & mask,
                                            job.depth + 3'd1));
                    jobs.push_back(make_job(1'b0, OPC_MVN, tmp, 4'd0, val & ~mask,
                                            job.depth + 3'd1));
                end
                else
                begin
                    jobs.push_back(make_job(1'b0, OPC_ORR, tmp, tmp, val & mask,
                                            job.depth + 3'd1));
                    jobs.push_back(make_job(1'b0, OPC_MOV, tmp, 4'd0, val & ~mask,
                                            job.depth + 3'd1));
                end
            end
        end

        for (int k = 0; k < words.size(); k++)
        begin
            exp_word.word = words[k];
            exp_word.last = (k == words.size() - 1);
            expected_words.push_back(exp_word);
        end
    endfunction

    function automatic logic [WORD_W-1:0] random_immediate();
        logic [WORD_W-1:0] byte_val;
        logic [WORD_W-1:0] rotated;
        logic [WORD_W-1:0] extra;
        int                rot_amount;
        byte_val   = $urandom_range(0, 255);
        rot_amount = 2 * $urandom_range(0, 15);
        rotated    = (byte_val >> rot_amount) | (byte_val << (32 - rot_amount));
        extra      = $urandom_range(0, 255);
        extra      = extra << (2 * $urandom_range(0, 12));
        case ($urandom_range(0, 7))
            0: return rotated;
            1: return ~rotated;
            2: return 32'd0 - rotated;
            3: return rotated | extra;
            4: return $urandom_range(0, 1) ? 32'h0000_0000 : 32'hffff_ffff;
            5: return $urandom & $urandom;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_request(input logic [MODE_W-1:0] mode, input logic [REG_W-1:0] rd,
                                input logic [REG_W-1:0] rn, input logic [WORD_W-1:0] imm);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 8);
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, imm, rn, rd, mode};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_words(mode, rd, rn, imm);
    endtask

    task automatic send_random_request(input bit split_value);
        logic [MODE_W-1:0] mode;
        logic [REG_W-1:0]  rd;
        logic [REG_W-1:0]  rn;
        logic [WORD_W-1:0] imm;
        if ($urandom_range(0, 9) < 7)
        begin
            case ($urandom_range(0, 7))
                0: mode = OPC_AND;
                1: mode = OPC_EOR;
                2: mode = OPC_SUB;
                3: mode = OPC_ADD;
                4: mode = OPC_ORR;
                5: mode = OPC_MOV;
                6: mode = OPC_BIC;
                default: mode = OPC_MVN;
            endcase
            mode[0] = 1'($urandom_range(0, 1));
        end
        else
            mode = 5'($urandom_range(0, 31));
        rd  = 4'($urandom_range(0, 15));
        rn  = ($urandom_range(0, 3) == 0) ? rd : 4'($urandom_range(0, 15));
        imm = split_value ? $urandom : random_immediate();
        send_request(mode, rd, rn, imm);
    endtask

    // Stop offering requests and wait until the block has gone quiet
    task automatic drain_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_scratch(input logic [REG_W-1:0] value);
        drain_results();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        scratch_model = value;
    endtask

    task automatic test_directed_encodings();
        // Requests that leave Rd unchanged give no words
        send_request(OPC_ADD, 4'd3, 4'd3, 32'h0000_0000);
        send_request(OPC_SUB, 4'd0, 4'd0, 32'h0000_0000);
        send_request(OPC_ORR, 4'd15, 4'd15, 32'h0000_0000);
        send_request(OPC_EOR, 4'd7, 4'd7, 32'h0000_0000);
        send_request(OPC_BIC, 4'd9, 4'd9, 32'h0000_0000);
        send_request(OPC_AND, 4'd4, 4'd4, 32'hffff_ffff);
        // Near misses of the above still encode
        send_request(OPC_ADD | S_BIT, 4'd3, 4'd3, 32'h0000_0000);
        send_request(OPC_AND, 4'd4, 4'd5, 32'hffff_ffff);
        // Cheaper forms
        send_request(OPC_ADD, 4'd1, 4'd2, 32'hffff_ff00);
        send_request(OPC_AND, 4'd3, 4'd4, 32'hffff_fff0);
        send_request(OPC_MOV, 4'd5, 4'd0, 32'hffff_ff00);
        send_request(OPC_MOV | S_BIT, 4'd5, 4'd0, 32'hffff_ffff);
        // Rotation extremes
        send_request(OPC_MOV, 4'd0, 4'd0, 32'h0000_00ff);
        send_request(OPC_ORR, 4'd1, 4'd2, 32'hff00_0000);
        send_request(OPC_EOR, 4'd1, 4'd2, 32'hc000_003f);
        send_request(OPC_SUB, 4'd15, 4'd15, 32'h8000_0001);
        // Split values: plain moves, flag-setting moves, compares and full operations
        send_request(OPC_MOV, 4'd8, 4'd0, 32'h1234_5678);
        send_request(OPC_MVN, 4'd8, 4'd0, 32'h1234_5678);
        send_request(OPC_MOV | S_BIT, 4'd8, 4'd0, 32'h1234_5678);
        send_request(OPC_MVN | S_BIT, 4'd15, 4'd15, 32'haaaa_aaaa);
        send_request(OPC_ADD, 4'd2, 4'd3, 32'h0012_3456);
        send_request(OPC_TST | S_BIT, 4'd0, 4'd11, 32'h00ff_00ff);
        send_request(OPC_ORR, 4'd0, 4'd15, 32'hffff_ffff);
        send_request(OPC_BIC | S_BIT, 4'd14, 4'd1, 32'h5555_5555);
    endtask

    task automatic test_scratch_register();
        write_scratch(4'd0);
        repeat (8) send_random_request(1'b1);
        write_scratch(4'd15);
        repeat (8) send_random_request(1'b1);
        write_scratch(4'($urandom_range(1, 14)));
        repeat (8) send_random_request(1'b1);
    endtask

    task automatic test_random_requests(input int count);
        for (int i = 0; i < count; i++)
        begin
            if (i == count / 2)
                write_scratch(4'($urandom_range(0, 15)));
            send_random_request($urandom_range(0, 3) == 0);
        end
    endtask

    task automatic test_steady_flow(input int count);
        drain_results();
        no_idle = 1'b1;
        repeat (count) send_random_request(1'b0);
        drain_results();
        no_idle = 1'b0;
    endtask

    // Hold the output off for a long stretch while requests keep coming
    task automatic test_output_backpressure(input int count);
        drain_results();
        no_idle = 1'b1;
        long_hold_requests++;
        repeat (count) send_random_request(1'b1);
        drain_results();
        no_idle = 1'b0;
    endtask

    initial
    begin : result_sink
        int long_hold_served;
        long_hold_served = 0;
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            // Draw a fresh idle count after every taken transaction
            if (rst_n && m_tvalid && m_tready)
                sink_stall = no_idle ? 0 : $urandom_range(0, 8);
            @(negedge clk);
            if (long_hold_served != long_hold_requests)
            begin
                sink_stall       = LONG_HOLD_CYCLES;
                long_hold_served = long_hold_requests;
            end
            if (sink_stall > 0)
            begin
                sink_stall--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : result_check
        expected_word_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_words.size() == 0)
            begin
                $display("%0t: unexpected transaction: expected none, actual %h last %b",
                         $time, m_tdata, m_tlast);
                mismatch_count++;
            end
            else
            begin
                want = expected_words.pop_front();
                if (m_tdata !== want.word)
                begin
                    $display("%0t: instruction word: expected %h, actual %h",
                             $time, want.word, m_tdata);
                    mismatch_count++;
                end
                if (m_tlast !== want.last)
                begin
                    $display("%0t: last flag for %h: expected %b, actual %b",
                             $time, want.word, want.last, m_tlast);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_we    = 1'b0;
        cfg_wdata = 4'd0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_encodings();
        test_scratch_register();
        test_random_requests(92);
        test_steady_flow(20);
        test_output_backpressure(10);
        drain_results();

        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #1_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

### arm_immediate_instruction_encoder_top.f
hw/rtl/aimmenc_pkg.sv
hw/rtl/aimmenc_shared_unit.sv
hw/rtl/aimmenc_seq.sv
hw/rtl/aimmenc_out_reg.sv
hw/rtl/arm_immediate_instruction_encoder_top.sv
verif/tb_top.sv
